// File: hw/rtl/bfa_pkg.sv
// Shared types and constants for the best-fit block allocator.
// Holds the sequencer state and continuation enums, operation and status codes.
// No dependencies.
package bfa_pkg;

	// Default geometry; ALIGN_BYTES is a power of two.
	localparam int ARENA_MAX_BYTES_DEF = 65536;
	localparam int ALIGN_BYTES_DEF     = 16;
	localparam int HEADER_BYTES_DEF    = 32;

	// Arena length taken after reset.
	localparam int ARENA_RESET_BYTES = 65536;

	// Operation codes on func.
	localparam logic [1:0] FN_ALLOC  = 2'd0;
	localparam logic [1:0] FN_FREE   = 2'd1;
	localparam logic [1:0] FN_RESIZE = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFIT  = 2'd1;
	localparam logic [1:0] ST_BADPTR = 2'd2;
	localparam logic [1:0] ST_DOUBLE = 2'd3;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_CLEAR,
		S_INIT,
		S_IDLE,
		S_DEC,
		S_SCAN,
		S_PICK,
		S_LOOK,
		S_NEXT,
		S_PLAN,
		S_W_OWN,
		S_W_SPLIT,
		S_W_UNHDR,
		S_W_PREV,
		S_ISSUE,
		S_PJOIN,
		S_DONE
	} state_t;

	// What follows a table update.
	typedef enum logic [1:0] {
		C_DONE,
		C_PREV,
		C_REL
	} cont_t;

endpackage

// File: hw/rtl/best_fit_block_allocator.sv
// Allocate walks every block header of the arena in a best-fit scan; free and in-place resize
// work on the block and its neighbors; resize to zero frees, and a relocating resize scans.
// Throughput: one item at a time; a new beat is taken in the idle cycle after the result is
// registered, even while that result waits. The table memory port sets the pace.
// Reset and every arena length write run a clearing pass over all units; no beat taken.
// Best-fit block allocator with coalescing, built around one unit-indexed table memory.
// Depends on bfa_pkg.
module best_fit_block_allocator #(
	parameter int ARENA_MAX_BYTES = bfa_pkg::ARENA_MAX_BYTES_DEF,
	parameter int ALIGN_BYTES     = bfa_pkg::ALIGN_BYTES_DEF,
	parameter int HEADER_BYTES    = bfa_pkg::HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [16:0] size_bytes,
	input  logic        has_pointer,
	input  logic [15:0] pointer_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        result_present,
	output logic [15:0] result_offset,
	output logic [16:0] copy_bytes
);

	localparam int LG        = $clog2(ALIGN_BYTES);
	localparam int HDR_UNITS = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int MAX_UNITS = ARENA_MAX_BYTES / ALIGN_BYTES;
	localparam int MIN_BYTES = (HDR_UNITS + 1) * ALIGN_BYTES;
	localparam int UW        = $clog2(MAX_UNITS);
	localparam int XW        = (UW + 2 > 18) ? UW + 2 : 18;

	localparam logic [XW-1:0] HDR_X = XW'(HDR_UNITS);
	localparam logic [XW-1:0] ONE_X = XW'(1);

	// Clamp an arena length and turn it into whole units.
	function automatic logic [XW-1:0] tot_of(input logic [16:0] b);
		logic [31:0] e;
		e = 32'(b);
		if (e > 32'(ARENA_MAX_BYTES)) begin
			e = 32'(ARENA_MAX_BYTES);
		end
		if (e < 32'(MIN_BYTES)) begin
			e = 32'(MIN_BYTES);
		end
		return XW'(e >> LG);
	endfunction

	// Control state.
	bfa_pkg::state_t state_q, state_d;
	logic [XW-1:0] tot_q;
	logic [UW-1:0] clr_q;
	logic          out_valid_q;

	// Item registers.
	logic [1:0]    func_q;
	logic [16:0]   size_q;
	logic          ptr_q;
	logic [15:0]   off_q;
	logic [XW-1:0] need_q;

	// Block under work and its neighbor.
	logic [UW-1:0] u_q, uu_q, up_q, n_q, nunits_q;
	logic          nv_q, nfree_q, rel_q, reloc_q;

	// Scan registers.
	logic [UW-1:0] scan_q, best_q, bestsz_q;
	logic          found_q;

	// Planned table update.
	logic [UW-1:0]   own_a_q, own_units_q;
	logic            own_free_q;
	logic            sp_en_q;
	logic [UW-1:0]   sp_a_q, sp_units_q, sp_prev_q;
	logic            uh_en_q;
	logic [UW-1:0]   uh_a_q;
	logic            pv_en_q;
	logic [UW-1:0]   pv_a_q, pv_val_q;
	bfa_pkg::cont_t  cont_q;

	// Result being built and result register.
	logic [1:0]  res_status_q;
	logic        res_present_q;
	logic [15:0] res_off_q;
	logic [16:0] res_copy_q;
	logic [1:0]  out_status_q;
	logic        out_present_q;
	logic [15:0] out_off_q;
	logic [16:0] out_copy_q;

	// Table memory, one field group per unit, with field write enables.
	logic          mem_hdr   [MAX_UNITS];
	logic          mem_free  [MAX_UNITS];
	logic [UW-1:0] mem_units [MAX_UNITS];
	logic [UW-1:0] mem_prev  [MAX_UNITS];
	logic          rd_hdr_q, rd_free_q;
	logic [UW-1:0] rd_units_q, rd_prev_q;
	logic [UW-1:0] rd_addr, w_addr;
	logic          we_hdr, we_free, we_units, we_prev;
	logic          w_hdr, w_free;
	logic [UW-1:0] w_units, w_prev;

	// Derived values.
	logic          in_acc, cfg_acc, out_load;
	logic          is_alloc, need_bad, look_bad, is_rel;
	logic [XW-1:0] q_x, scan_nx, look_nx, m_x, r_x, run_x, after_x, ge_x, e_x;
	logic [XW-1:0] t_nx, pm_x, pe_x;
	logic          scan_hit, t_split, a_split, g_split, fits_in, grow_ok;
	logic [31:0]   have_w;

	assign in_acc   = in_valid && in_ready;
	assign cfg_acc  = cfg_valid && cfg_ready;
	assign out_load = (state_q == bfa_pkg::S_DONE) && (!out_valid_q || out_ready);

	// Decode and lookup checks.
	assign is_alloc = (func_q == bfa_pkg::FN_ALLOC) || ((func_q == bfa_pkg::FN_RESIZE) && !ptr_q);
	assign need_bad = (need_q == '0) || (need_q > tot_q);
	assign q_x      = XW'(off_q >> LG);
	assign look_bad = (off_q[LG-1:0] != '0) || (q_x < HDR_X) || ((q_x - HDR_X) >= tot_q);
	assign is_rel   = rel_q || (func_q == bfa_pkg::FN_FREE) || (size_q == '0);

	// Scan step over one header.
	assign scan_nx  = XW'(scan_q) + HDR_X + XW'(rd_units_q);
	assign scan_hit = rd_free_q && (XW'(rd_units_q) >= need_q) &&
		(!found_q || (rd_units_q < bestsz_q));
	assign look_nx  = XW'(u_q) + HDR_X + XW'(rd_units_q);

	// Take of the best block.
	assign t_split = XW'(bestsz_q) >= need_q + HDR_X + ONE_X;
	assign t_nx    = XW'(best_q) + HDR_X + XW'(bestsz_q);
	assign have_w  = 32'(uu_q) << LG;

	// Release, shrink and grow plans.
	assign m_x     = XW'(uu_q) + HDR_X + XW'(nunits_q);
	assign e_x     = XW'(n_q) + HDR_X + XW'(nunits_q);
	assign fits_in = need_q <= XW'(uu_q);
	assign a_split = XW'(uu_q) >= need_q + HDR_X + ONE_X;
	assign r_x     = XW'(u_q) + HDR_X + need_q;
	assign run_x   = XW'(uu_q) - need_q - HDR_X + (nfree_q ? HDR_X + XW'(nunits_q) : '0);
	assign after_x = r_x + HDR_X + run_x;
	assign grow_ok = nfree_q && (m_x >= need_q);
	assign g_split = m_x >= need_q + HDR_X + ONE_X;
	assign ge_x    = XW'(u_q) + HDR_X + m_x;

	// Join with the previous block.
	assign pm_x = XW'(rd_units_q) + HDR_X + XW'(uu_q);
	assign pe_x = XW'(up_q) + HDR_X + pm_x;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bfa_pkg::S_CLEAR: begin
				if (clr_q == UW'(MAX_UNITS - 1)) begin
					state_d = bfa_pkg::S_INIT;
				end
			end
			bfa_pkg::S_INIT:  state_d = bfa_pkg::S_IDLE;
			bfa_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = bfa_pkg::S_DEC;
				end
			end
			bfa_pkg::S_DEC: begin
				if (is_alloc) begin
					state_d = need_bad ? bfa_pkg::S_DONE : bfa_pkg::S_SCAN;
				end else if ((func_q == bfa_pkg::FN_FREE) && !ptr_q) begin
					state_d = bfa_pkg::S_DONE;
				end else if (func_q inside {bfa_pkg::FN_FREE, bfa_pkg::FN_RESIZE}) begin
					state_d = look_bad ? bfa_pkg::S_DONE : bfa_pkg::S_LOOK;
				end else begin
					state_d = bfa_pkg::S_DONE;
				end
			end
			bfa_pkg::S_SCAN: begin
				if (scan_nx >= tot_q) begin
					state_d = bfa_pkg::S_PICK;
				end
			end
			bfa_pkg::S_PICK: state_d = found_q ? bfa_pkg::S_W_OWN : bfa_pkg::S_DONE;
			bfa_pkg::S_LOOK: begin
				if (!rel_q && (!rd_hdr_q || rd_free_q)) begin
					state_d = bfa_pkg::S_DONE;
				end else begin
					state_d = bfa_pkg::S_NEXT;
				end
			end
			bfa_pkg::S_NEXT: state_d = bfa_pkg::S_PLAN;
			bfa_pkg::S_PLAN: begin
				if (is_rel) begin
					state_d = bfa_pkg::S_W_OWN;
				end else if (fits_in) begin
					state_d = a_split ? bfa_pkg::S_W_OWN : bfa_pkg::S_DONE;
				end else if (grow_ok) begin
					state_d = bfa_pkg::S_W_OWN;
				end else if (need_q > tot_q) begin
					state_d = bfa_pkg::S_DONE;
				end else begin
					state_d = bfa_pkg::S_SCAN;
				end
			end
			bfa_pkg::S_W_OWN:   state_d = bfa_pkg::S_W_SPLIT;
			bfa_pkg::S_W_SPLIT: state_d = bfa_pkg::S_W_UNHDR;
			bfa_pkg::S_W_UNHDR: state_d = bfa_pkg::S_W_PREV;
			bfa_pkg::S_W_PREV: begin
				if (cont_q == bfa_pkg::C_DONE) begin
					state_d = bfa_pkg::S_DONE;
				end else if ((cont_q == bfa_pkg::C_PREV) && (u_q == '0)) begin
					state_d = bfa_pkg::S_DONE;
				end else begin
					state_d = bfa_pkg::S_ISSUE;
				end
			end
			bfa_pkg::S_ISSUE: begin
				state_d = (cont_q == bfa_pkg::C_REL) ? bfa_pkg::S_LOOK : bfa_pkg::S_PJOIN;
			end
			bfa_pkg::S_PJOIN: state_d = rd_free_q ? bfa_pkg::S_W_OWN : bfa_pkg::S_DONE;
			bfa_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = bfa_pkg::S_IDLE;
				end
			end
			default: state_d = bfa_pkg::S_CLEAR;
		endcase
		if (cfg_acc) begin
			state_d = bfa_pkg::S_CLEAR;
		end
	end

	// Handshake and memory port control.
	always_comb begin
		cfg_ready = (state_q inside {bfa_pkg::S_CLEAR, bfa_pkg::S_INIT, bfa_pkg::S_IDLE});
		in_ready  = (state_q == bfa_pkg::S_IDLE) && !cfg_valid;
		rd_addr   = '0;
		w_addr    = '0;
		we_hdr    = 1'b0;
		we_free   = 1'b0;
		we_units  = 1'b0;
		we_prev   = 1'b0;
		w_hdr     = 1'b0;
		w_free    = 1'b0;
		w_units   = '0;
		w_prev    = '0;
		case (state_q)
			bfa_pkg::S_CLEAR: begin
				w_addr   = clr_q;
				we_hdr   = 1'b1;
				we_free  = 1'b1;
				we_units = 1'b1;
				we_prev  = 1'b1;
			end
			bfa_pkg::S_INIT: begin
				we_hdr   = 1'b1;
				we_free  = 1'b1;
				we_units = 1'b1;
				we_prev  = 1'b1;
				w_hdr    = 1'b1;
				w_free   = 1'b1;
				w_units  = UW'(tot_q - HDR_X);
			end
			bfa_pkg::S_DEC:  rd_addr = is_alloc ? '0 : UW'(q_x - HDR_X);
			bfa_pkg::S_SCAN: rd_addr = UW'(scan_nx);
			bfa_pkg::S_LOOK: rd_addr = UW'(look_nx);
			bfa_pkg::S_W_OWN: begin
				w_addr   = own_a_q;
				we_units = 1'b1;
				we_free  = 1'b1;
				w_units  = own_units_q;
				w_free   = own_free_q;
			end
			bfa_pkg::S_W_SPLIT: begin
				w_addr   = sp_a_q;
				we_hdr   = sp_en_q;
				we_free  = sp_en_q;
				we_units = sp_en_q;
				we_prev  = sp_en_q;
				w_hdr    = 1'b1;
				w_free   = 1'b1;
				w_units  = sp_units_q;
				w_prev   = sp_prev_q;
			end
			bfa_pkg::S_W_UNHDR: begin
				w_addr = uh_a_q;
				we_hdr = uh_en_q;
			end
			bfa_pkg::S_W_PREV: begin
				w_addr  = pv_a_q;
				we_prev = pv_en_q;
				w_prev  = pv_val_q;
			end
			bfa_pkg::S_ISSUE: rd_addr = (cont_q == bfa_pkg::C_REL) ? u_q : up_q;
			default: rd_addr = '0;
		endcase
	end

	// Table memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we_hdr) begin
			mem_hdr[w_addr] <= w_hdr;
		end
		if (we_free) begin
			mem_free[w_addr] <= w_free;
		end
		if (we_units) begin
			mem_units[w_addr] <= w_units;
		end
		if (we_prev) begin
			mem_prev[w_addr] <= w_prev;
		end
		rd_hdr_q   <= mem_hdr[rd_addr];
		rd_free_q  <= mem_free[rd_addr];
		rd_units_q <= mem_units[rd_addr];
		rd_prev_q  <= mem_prev[rd_addr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfa_pkg::S_CLEAR;
			clr_q       <= '0;
			tot_q       <= tot_of(17'(bfa_pkg::ARENA_RESET_BYTES));
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				tot_q <= tot_of(cfg_wdata);
				clr_q <= '0;
			end else if (state_q == bfa_pkg::S_CLEAR) begin
				clr_q <= clr_q + UW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers, updated per sequencer step.
	always_ff @(posedge clk) begin
		case (state_q)
			bfa_pkg::S_IDLE: begin
				if (in_acc) begin
					func_q        <= func;
					size_q        <= size_bytes;
					ptr_q         <= has_pointer;
					off_q         <= pointer_offset;
					need_q        <= XW'((18'(size_bytes) + 18'(ALIGN_BYTES - 1)) >> LG);
					res_status_q  <= bfa_pkg::ST_NOFIT;
					res_present_q <= 1'b0;
					res_off_q     <= '0;
					res_copy_q    <= '0;
					rel_q         <= 1'b0;
					reloc_q       <= 1'b0;
				end
			end
			bfa_pkg::S_DEC: begin
				scan_q  <= '0;
				found_q <= 1'b0;
				if (!is_alloc) begin
					if ((func_q == bfa_pkg::FN_FREE) && !ptr_q) begin
						res_status_q <= bfa_pkg::ST_OK;
					end else if (func_q inside {bfa_pkg::FN_FREE, bfa_pkg::FN_RESIZE}) begin
						if (look_bad) begin
							res_status_q <= bfa_pkg::ST_BADPTR;
						end
						u_q <= UW'(q_x - HDR_X);
					end
				end
			end
			bfa_pkg::S_SCAN: begin
				if (scan_hit) begin
					best_q   <= scan_q;
					bestsz_q <= rd_units_q;
					found_q  <= 1'b1;
				end
				scan_q <= UW'(scan_nx);
			end
			bfa_pkg::S_PICK: begin
				// Take the best block, splitting off the rest when it holds a header and a unit.
				own_a_q     <= best_q;
				own_units_q <= t_split ? UW'(need_q) : bestsz_q;
				own_free_q  <= 1'b0;
				sp_en_q     <= t_split;
				sp_a_q      <= UW'(XW'(best_q) + HDR_X + need_q);
				sp_units_q  <= UW'(XW'(bestsz_q) - need_q - HDR_X);
				sp_prev_q   <= best_q;
				uh_en_q     <= 1'b0;
				pv_en_q     <= t_split && (t_nx < tot_q);
				pv_a_q      <= UW'(t_nx);
				pv_val_q    <= UW'(XW'(best_q) + HDR_X + need_q);
				if (found_q) begin
					res_status_q  <= bfa_pkg::ST_OK;
					res_present_q <= 1'b1;
					res_off_q     <= 16'((32'(best_q) + 32'(HDR_UNITS)) << LG);
					if (reloc_q) begin
						res_copy_q <= 17'((have_w < 32'(size_q)) ? have_w : 32'(size_q));
						rel_q      <= 1'b1;
					end
				end
				cont_q <= reloc_q ? bfa_pkg::C_REL : bfa_pkg::C_DONE;
			end
			bfa_pkg::S_LOOK: begin
				uu_q <= rd_units_q;
				up_q <= rd_prev_q;
				n_q  <= UW'(look_nx);
				nv_q <= look_nx < tot_q;
				if (!rel_q) begin
					if (!rd_hdr_q) begin
						res_status_q <= bfa_pkg::ST_BADPTR;
					end else if (rd_free_q) begin
						res_status_q <= bfa_pkg::ST_DOUBLE;
					end
				end
			end
			bfa_pkg::S_NEXT: begin
				nfree_q  <= nv_q && rd_free_q;
				nunits_q <= rd_units_q;
			end
			bfa_pkg::S_PLAN: begin
				own_a_q <= u_q;
				cont_q  <= bfa_pkg::C_DONE;
				if (is_rel) begin
					// Release and merge with a free next block.
					own_units_q <= nfree_q ? UW'(m_x) : uu_q;
					uu_q        <= nfree_q ? UW'(m_x) : uu_q;
					own_free_q  <= 1'b1;
					sp_en_q     <= 1'b0;
					uh_en_q     <= nfree_q;
					uh_a_q      <= n_q;
					pv_en_q     <= nfree_q && (e_x < tot_q);
					pv_a_q      <= UW'(e_x);
					pv_val_q    <= u_q;
					cont_q      <= bfa_pkg::C_PREV;
					if (!rel_q && (func_q == bfa_pkg::FN_FREE)) begin
						res_status_q <= bfa_pkg::ST_OK;
					end
				end else if (fits_in) begin
					// Shrink in place; the cut rest absorbs a free next block.
					own_units_q   <= UW'(need_q);
					own_free_q    <= 1'b0;
					sp_en_q       <= 1'b1;
					sp_a_q        <= UW'(r_x);
					sp_units_q    <= UW'(run_x);
					sp_prev_q     <= u_q;
					uh_en_q       <= nfree_q;
					uh_a_q        <= n_q;
					pv_en_q       <= after_x < tot_q;
					pv_a_q        <= UW'(after_x);
					pv_val_q      <= UW'(r_x);
					res_status_q  <= bfa_pkg::ST_OK;
					res_present_q <= 1'b1;
					res_off_q     <= off_q;
				end else if (grow_ok) begin
					// Grow into the free next block, cutting off what is left over.
					own_units_q   <= g_split ? UW'(need_q) : UW'(m_x);
					own_free_q    <= 1'b0;
					sp_en_q       <= g_split;
					sp_a_q        <= UW'(r_x);
					sp_units_q    <= UW'(m_x - need_q - HDR_X);
					sp_prev_q     <= u_q;
					uh_en_q       <= 1'b1;
					uh_a_q        <= n_q;
					pv_en_q       <= ge_x < tot_q;
					pv_a_q        <= UW'(ge_x);
					pv_val_q      <= g_split ? UW'(r_x) : u_q;
					res_status_q  <= bfa_pkg::ST_OK;
					res_present_q <= 1'b1;
					res_off_q     <= off_q;
				end else begin
					// Relocate: search for a fresh block first.
					scan_q  <= '0;
					found_q <= 1'b0;
					reloc_q <= 1'b1;
				end
			end
			bfa_pkg::S_PJOIN: begin
				// Merge the released block into a free previous block.
				own_a_q     <= up_q;
				own_units_q <= UW'(pm_x);
				own_free_q  <= 1'b1;
				sp_en_q     <= 1'b0;
				uh_en_q     <= 1'b1;
				uh_a_q      <= u_q;
				pv_en_q     <= pe_x < tot_q;
				pv_a_q      <= UW'(pe_x);
				pv_val_q    <= up_q;
				cont_q      <= bfa_pkg::C_DONE;
			end
			bfa_pkg::S_DONE: begin
				if (out_load) begin
					out_status_q  <= res_status_q;
					out_present_q <= res_present_q;
					out_off_q     <= res_off_q;
					out_copy_q    <= res_copy_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign result_present = out_present_q;
	assign result_offset  = out_off_q;
	assign copy_bytes     = out_copy_q;

`ifndef NO_ASSERTIONS
	// A finished result is registered and the sequencer goes back to idle.
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && (state_q == bfa_pkg::S_IDLE || state_q == bfa_pkg::S_CLEAR))
		else $error("result not registered after completion");

	// The scan never walks past the end of the arena.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfa_pkg::S_SCAN) |-> (XW'(scan_q) < tot_q))
		else $error("scan beyond arena");

	// Back-link updates stay inside the arena.
	a_prev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfa_pkg::S_W_PREV && pv_en_q) |-> (XW'(pv_a_q) < tot_q))
		else $error("back-link write beyond arena");

	// A pointer is only returned with an ok status.
	a_present_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_present_q) |-> (out_status_q == bfa_pkg::ST_OK))
		else $error("pointer returned with error status");
`endif

endmodule
